/* src/alir_pkg.sv */
// ----------------------------------------------------------------------------
// alir_pkg
// Types and codes shared by the list controller, datapath and top level.
// ----------------------------------------------------------------------------
package alir_pkg;

  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 6;
  localparam int TOT_W  = 6;

  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_PURGE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] operand_value;
  } req_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic                     last;
    logic [TOT_W-1:0]         entry_total;
  } rsp_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_COUNT,
    PTR_POS1,
    PTR_CLEAR,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [2:0] {
    SCAN_NONE,
    SCAN_UP,
    SCAN_DOWN,
    SCAN_PACK,
    SCAN_READ
  } scan_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_AT_COUNT,
    WR_AT_POS
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_LOAD_J
  } cnt_op_t;

  typedef enum logic [1:0] {
    RSP_NONE,
    RSP_DONE,
    RSP_ENTRY
  } rsp_op_t;

  typedef struct packed {
    logic     latch;
    logic     st_load;
    logic     st_value;
    logic     j_clear;
    ptr_op_t  ptr_op;
    scan_op_t scan_op;
    wr_op_t   wr_op;
    cnt_op_t  cnt_op;
    rsp_op_t  rsp_op;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            ins_ok;
    logic            rem_ok;
    logic            empty;
    logic            ptr_gt_pos;
    logic            ptr_lt_count;
    logic            dump_last;
    logic            pend;
    logic            out_free;
  } dp_status_t;

endpackage

/* src/alir_datapath.sv */
// ----------------------------------------------------------------------------
// alir_datapath
// List store, scan pointers, entry count, capacity register and result word.
// ----------------------------------------------------------------------------
module alir_datapath #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  alir_pkg::req_t            req,
  input  logic                      cfg_valid,
  input  logic [alir_pkg::CFG_W-1:0] cfg_data,
  input  alir_pkg::dp_cmd_t         cmd,
  output alir_pkg::dp_status_t      status,
  output alir_pkg::rsp_t            rsp,
  output logic                      rsp_valid,
  input  logic                      rsp_ready
);
  import alir_pkg::*;

  localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] DEPTH_X = CMPW'(LIST_DEPTH);

  logic [DATA_W-1:0] mem [LIST_DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CFG_W-1:0]  capacity;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     j;
  logic              st_q;
  logic              pend;
  logic              pend_pack;
  logic [AW-1:0]     pend_dst;

  logic [CW-1:0]     ptr_m1;
  logic [CW-1:0]     ptr_p1;
  logic [CMPW-1:0]   count_x;
  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   cap_x;
  logic [CMPW-1:0]   limit;
  logic              keep;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  assign ptr_m1  = ptr - CW'(1);
  assign ptr_p1  = ptr + CW'(1);
  assign count_x = CMPW'(count);
  assign pos_x   = CMPW'(pos_q);
  assign cap_x   = CMPW'(capacity);
  assign limit   = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
  assign keep    = !pend_pack || (rdata != val_q);

  always_comb begin
    status.op           = op_q;
    status.full         = (count_x >= limit) || (count_x >= DEPTH_X);
    status.ins_ok       = !status.full && (pos_x <= count_x);
    status.rem_ok       = pos_x < count_x;
    status.empty        = count == '0;
    status.ptr_gt_pos   = CMPW'(ptr) > pos_x;
    status.ptr_lt_count = ptr < count;
    status.dump_last    = ptr_p1 == count;
    status.pend         = pend;
    status.out_free     = !rsp_valid || rsp_ready;
  end

  always_comb begin
    mem_re = cmd.scan_op != SCAN_NONE;
    mem_ra = (cmd.scan_op == SCAN_UP) ? ptr_m1[AW-1:0] : ptr[AW-1:0];
    mem_we = 1'b0;
    mem_wa = pend_dst;
    mem_wd = rdata;
    if (pend) begin
      mem_we = keep;
      mem_wa = pend_pack ? j[AW-1:0] : pend_dst;
    end else begin
      case (cmd.wr_op)
        WR_AT_COUNT: begin
          mem_we = 1'b1;
          mem_wa = count[AW-1:0];
          mem_wd = val_q;
        end
        WR_AT_POS: begin
          mem_we = 1'b1;
          mem_wa = AW'(pos_q);
          mem_wd = val_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= req.operation;
      pos_q <= req.position;
      val_q <= req.operand_value;
    end
    if (cmd.st_load) st_q <= cmd.st_value;
    pend_dst <= (cmd.scan_op == SCAN_UP) ? ptr[AW-1:0] : ptr_m1[AW-1:0];
    case (cmd.rsp_op)
      RSP_DONE: begin
        rsp.status        <= st_q;
        rsp.element       <= '0;
        rsp.element_valid <= 1'b0;
        rsp.last          <= 1'b1;
        rsp.entry_total   <= TOT_W'(count);
      end
      RSP_ENTRY: begin
        rsp.status        <= 1'b0;
        rsp.element       <= rdata;
        rsp.element_valid <= 1'b1;
        rsp.last          <= status.dump_last;
        rsp.entry_total   <= TOT_W'(count);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      count     <= '0;
      ptr       <= '0;
      j         <= '0;
      pend      <= 1'b0;
      pend_pack <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) capacity <= cfg_data;

      case (cmd.cnt_op)
        CNT_INC:    count <= count + CW'(1);
        CNT_DEC:    count <= count - CW'(1);
        CNT_LOAD_J: count <= j;
        default: ;
      endcase

      case (cmd.ptr_op)
        PTR_COUNT: ptr <= count;
        PTR_POS1:  ptr <= CW'(pos_x + CMPW'(1));
        PTR_CLEAR: ptr <= '0;
        PTR_INC:   ptr <= ptr_p1;
        PTR_DEC:   ptr <= ptr_m1;
        default: ;
      endcase

      if (cmd.j_clear) begin
        j <= '0;
      end else if (pend && pend_pack && keep) begin
        j <= j + CW'(1);
      end

      pend      <= (cmd.scan_op == SCAN_UP) || (cmd.scan_op == SCAN_DOWN) ||
                   (cmd.scan_op == SCAN_PACK);
      pend_pack <= cmd.scan_op == SCAN_PACK;

      if (cmd.rsp_op != RSP_NONE) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/alir_ctrl.sv */
// ----------------------------------------------------------------------------
// alir_ctrl
// Command sequencer: decodes one request word and steps the datapath scans.
// ----------------------------------------------------------------------------
module alir_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  alir_pkg::dp_status_t status,
  output alir_pkg::dp_cmd_t    cmd
);
  import alir_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_INS_WRITE,
    S_SHIFT_DOWN,
    S_PACK,
    S_DUMP_READ,
    S_DUMP_OUT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next   = state;
    cmd.latch    = 1'b0;
    cmd.st_load  = 1'b0;
    cmd.st_value = 1'b0;
    cmd.j_clear  = 1'b0;
    cmd.ptr_op   = PTR_HOLD;
    cmd.scan_op  = SCAN_NONE;
    cmd.wr_op    = WR_NONE;
    cmd.cnt_op   = CNT_HOLD;
    cmd.rsp_op   = RSP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.st_load = 1'b1;
        state_next  = S_FINISH;
        case (status.op)
          OP_APPEND: begin
            if (status.full) begin
              cmd.st_value = 1'b1;
            end else begin
              cmd.wr_op  = WR_AT_COUNT;
              cmd.cnt_op = CNT_INC;
            end
          end
          OP_INSERT: begin
            if (status.ins_ok) begin
              cmd.ptr_op = PTR_COUNT;
              state_next = S_SHIFT_UP;
            end else begin
              cmd.st_value = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (status.rem_ok) begin
              cmd.ptr_op = PTR_POS1;
              state_next = S_SHIFT_DOWN;
            end else begin
              cmd.st_value = 1'b1;
            end
          end
          OP_PURGE: begin
            cmd.ptr_op  = PTR_CLEAR;
            cmd.j_clear = 1'b1;
            state_next  = S_PACK;
          end
          OP_DUMP: begin
            if (!status.empty) begin
              cmd.ptr_op = PTR_CLEAR;
              state_next = S_DUMP_READ;
            end
          end
          default: cmd.st_value = 1'b1;
        endcase
      end
      S_SHIFT_UP: begin
        if (status.ptr_gt_pos) begin
          cmd.scan_op = SCAN_UP;
          cmd.ptr_op  = PTR_DEC;
        end else begin
          state_next = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        // last copy drains first, one write port
        if (!status.pend) begin
          cmd.wr_op  = WR_AT_POS;
          cmd.cnt_op = CNT_INC;
          state_next = S_FINISH;
        end
      end
      S_SHIFT_DOWN: begin
        if (status.ptr_lt_count) begin
          cmd.scan_op = SCAN_DOWN;
          cmd.ptr_op  = PTR_INC;
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_FINISH;
        end
      end
      S_PACK: begin
        if (status.ptr_lt_count) begin
          cmd.scan_op = SCAN_PACK;
          cmd.ptr_op  = PTR_INC;
        end else if (!status.pend) begin
          cmd.cnt_op = CNT_LOAD_J;
          state_next = S_FINISH;
        end
      end
      S_DUMP_READ: begin
        cmd.scan_op = SCAN_READ;
        state_next  = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (status.out_free) begin
          cmd.rsp_op = RSP_ENTRY;
          cmd.ptr_op = PTR_INC;
          state_next = status.dump_last ? S_IDLE : S_DUMP_READ;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.rsp_op = RSP_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* src/array_list_insert_remove_unit.sv */
// ----------------------------------------------------------------------------
// array_list_insert_remove_unit
// Bounded ordered list of signed words with append, insert, remove, purge, dump.
// ----------------------------------------------------------------------------
// Throughput: one request word at a time; the shift and purge scans move one
//   entry per cycle through the list store, which has one read port and one
//   write port, with registered read data.
// Reset: entry count 0, capacity 32, result channel empty; store contents kept.
// ----------------------------------------------------------------------------
module array_list_insert_remove_unit #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  alir_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output alir_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [alir_pkg::CFG_W-1:0] cfg_data
);
  import alir_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  alir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  alir_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule

/* tb/list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the request, result and capacity channels of the list unit, keeps
// its own copy of the list, works out the result words each accepted request
// must give, and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module list_checker #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  alir_pkg::req_t             req,
  input  logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  alir_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [alir_pkg::CFG_W-1:0] cfg_data,
  output int                         mismatches,
  output int                         awaited,
  output int                         held_entries,
  output int                         commands_seen,
  output int                         words_checked,
  output int                         cap_writes
);
  import alir_pkg::*;

  logic signed [DATA_W-1:0] shadow [LIST_DEPTH];
  logic [CFG_W-1:0]         cap_reg = CAP_RESET;
  int                       fill    = 0;
  rsp_t                     due_words [$];
  int                       n_bad   = 0;
  int                       n_cmd   = 0;
  int                       n_chk   = 0;
  int                       n_cfg   = 0;

  function automatic void queue_word(logic st, logic signed [DATA_W-1:0] el, logic ev,
                                     logic fin);
    rsp_t w;
    w.status        = st;
    w.element       = el;
    w.element_valid = ev;
    w.last          = fin;
    w.entry_total   = TOT_W'(fill);
    due_words.push_back(w);
  endfunction

  function automatic void apply_command(req_t c);
    int lim;
    int at;
    int keep;
    lim = (int'(cap_reg) > LIST_DEPTH) ? LIST_DEPTH : int'(cap_reg);
    at  = int'(c.position);
    case (c.operation)
      OP_APPEND: begin
        if (fill >= lim) begin
          queue_word(1'b1, '0, 1'b0, 1'b1);
        end else begin
          shadow[fill] = c.operand_value;
          fill++;
          queue_word(1'b0, '0, 1'b0, 1'b1);
        end
      end
      OP_INSERT: begin
        if (fill >= lim || at > fill) begin
          queue_word(1'b1, '0, 1'b0, 1'b1);
        end else begin
          for (int i = fill; i > at; i--) shadow[i] = shadow[i-1];
          shadow[at] = c.operand_value;
          fill++;
          queue_word(1'b0, '0, 1'b0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (at >= fill) begin
          queue_word(1'b1, '0, 1'b0, 1'b1);
        end else begin
          for (int i = at + 1; i < fill; i++) shadow[i-1] = shadow[i];
          fill--;
          queue_word(1'b0, '0, 1'b0, 1'b1);
        end
      end
      OP_PURGE: begin
        keep = 0;
        for (int i = 0; i < fill; i++) begin
          if (shadow[i] != c.operand_value) begin
            shadow[keep] = shadow[i];
            keep++;
          end
        end
        fill = keep;
        queue_word(1'b0, '0, 1'b0, 1'b1);
      end
      OP_DUMP: begin
        if (fill == 0) begin
          queue_word(1'b0, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < fill; i++) queue_word(1'b0, shadow[i], 1'b1, i == fill - 1);
        end
      end
      default: queue_word(1'b1, '0, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_word(rsp_t got);
    rsp_t want;
    if (due_words.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%0t: unexpected result word: status=%0d element=%0d ev=%0d last=%0d total=%0d",
                 $realtime, got.status, got.element, got.element_valid, got.last,
                 got.entry_total);
    end else begin
      want = due_words.pop_front();
      n_chk++;
      if (got.status !== want.status || got.element !== want.element ||
          got.element_valid !== want.element_valid || got.last !== want.last ||
          got.entry_total !== want.entry_total) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("%0t: result word %0d mismatch", $realtime, n_chk);
          $display("  expected status=%0d element=%0d ev=%0d last=%0d total=%0d",
                   want.status, want.element, want.element_valid, want.last,
                   want.entry_total);
          $display("  actual   status=%0d element=%0d ev=%0d last=%0d total=%0d",
                   got.status, got.element, got.element_valid, got.last, got.entry_total);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill    = 0;
      cap_reg = CAP_RESET;
      due_words.delete();
    end else begin
      // results first: a word leaving now belongs to an older request
      if (rsp_valid && rsp_ready) check_word(rsp);
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        n_cfg++;
      end
      if (req_valid && req_ready) begin
        apply_command(req);
        n_cmd++;
      end
    end
    mismatches    <= n_bad;
    awaited       <= due_words.size();
    held_entries  <= fill;
    commands_seen <= n_cmd;
    words_checked <= n_chk;
    cap_writes    <= n_cfg;
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the list unit with directed and random commands under random idling
// on both channels, steps the capacity through its extremes between phases,
// and reports the verdict from the checker's mismatch and awaited-word counts.
// ----------------------------------------------------------------------------
module tb;
  import alir_pkg::*;

  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int IDLE_PCT    = 17;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;
  bit               steady    = 1'b0;
  int               cycles    = 0;

  int mismatches, awaited, held_entries, commands_seen, words_checked, cap_writes;

  int phase_cap   [5] = '{1, 0, 7, 32, 20};
  int phase_items [5] = '{12, 10, 15, 20, 20};
  int phase_bias  [5] = '{20, 20, 40, 30, 35};

  always #4 clk = ~clk;

  array_list_insert_remove_unit #(.LIST_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  list_checker #(.LIST_DEPTH(DEPTH)) list_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .held_entries  (held_entries),
    .commands_seen (commands_seen),
    .words_checked (words_checked),
    .cap_writes    (cap_writes)
  );

  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic req_t cmd(logic [OP_W-1:0] op, int pos, logic signed [DATA_W-1:0] val);
    req_t c;
    c.operation     = op;
    c.position      = POS_W'(pos);
    c.operand_value = val;
    return c;
  endfunction

  // small values dominate so that purges find matches
  function automatic logic signed [DATA_W-1:0] rand_value();
    int k;
    k = $urandom_range(9);
    if (k < 4) return int'($urandom_range(0, 6)) - 3;
    if (k < 7) return $urandom();
    if (k == 7) return 32'sh7fffffff;
    if (k == 8) return 32'sh80000000;
    return '0;
  endfunction

  function automatic req_t pick_command(int append_pct);
    req_t c;
    int   k;
    c.operand_value = rand_value();
    c.position      = POS_W'($urandom_range(0, 63));
    c.operation     = OP_APPEND;
    k = $urandom_range(99);
    if (k >= append_pct) begin
      k = $urandom_range(99);
      if (k < 30) begin
        c.operation = OP_INSERT;
        if ($urandom_range(9) < 8) c.position = POS_W'($urandom_range(0, held_entries));
      end else if (k < 55) begin
        c.operation = OP_REMOVE;
        if (held_entries > 0 && $urandom_range(9) < 8)
          c.position = POS_W'($urandom_range(0, held_entries - 1));
      end else if (k < 68) begin
        c.operation = OP_PURGE;
      end else if (k < 90) begin
        c.operation = OP_DUMP;
      end else if (k < 95) begin
        c.operation = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
    end
    return c;
  endfunction

  task automatic send_command(req_t w);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  task automatic write_capacity(int v);
    cfg_data  <= CFG_W'(v);
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty list, ends of the value range, edge positions
    send_command(cmd(OP_DUMP, 0, 0));
    send_command(cmd(OP_REMOVE, 0, 0));
    send_command(cmd(OP_PURGE, 0, 5));
    send_command(cmd(OP_APPEND, 0, 32'sh7fffffff));
    send_command(cmd(OP_APPEND, 63, 32'sh80000000));
    send_command(cmd(OP_INSERT, 0, -32'sd1));
    send_command(cmd(OP_INSERT, 3, 0));
    send_command(cmd(OP_INSERT, 5, 9));
    send_command(cmd(OP_INSERT, 63, 9));
    send_command(cmd(OP_DUMP, 0, 0));
    send_command(cmd(OP_REMOVE, 1, 0));
    send_command(cmd(OP_REMOVE, 3, 0));
    send_command(cmd(OP_REMOVE, 63, 0));
    send_command(cmd(OP_APPEND, 0, 5));
    send_command(cmd(OP_APPEND, 0, 7));
    send_command(cmd(OP_APPEND, 0, 5));
    send_command(cmd(OP_PURGE, 0, 5));
    send_command(cmd(OP_PURGE, 0, 12345));
    send_command(cmd(OP_SPARE_LO, 0, 0));
    send_command(cmd(OP_SPARE_LO + 3'd1, 42, -32'sd7));
    send_command(cmd(OP_SPARE_HI, 63, -32'sd1));
    send_command(cmd(OP_REMOVE, 0, 0));
    send_command(cmd(OP_DUMP, 0, 0));

    // capacity above depth clamps: fill to full, then overflow
    drain();
    write_capacity(63);
    while (held_entries < DEPTH) send_command(cmd(OP_APPEND, $urandom_range(0, 63), rand_value()));
    send_command(cmd(OP_APPEND, 0, 1));
    send_command(cmd(OP_INSERT, 0, 1));
    send_command(cmd(OP_DUMP, 0, 0));
    for (int n = 0; n < 10; n++) send_command(pick_command(30));

    for (int p = 0; p < 5; p++) begin
      drain();
      write_capacity(phase_cap[p]);
      steady = (phase_cap[p] == DEPTH);
      for (int n = 0; n < phase_items[p]; n++) begin
        if (n == phase_items[p] / 2 && p == 4) drain();
        send_command(pick_command(phase_bias[p]));
      end
    end
    steady = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    $display("Ran %0d list commands over %0d capacity writes; %0d result words checked.",
             commands_seen, cap_writes, words_checked);
    $display({"Covered full, empty and over-limit lists, edge inserts and removes, ",
              "purges, dumps, spare opcodes."});
    if (mismatches == 0 && awaited == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* array_list_insert_remove_unit.f */
src/alir_pkg.sv
src/alir_datapath.sv
src/alir_ctrl.sv
src/array_list_insert_remove_unit.sv
tb/list_checker.sv
tb/tb.sv
